// ===== hw/rtl/gdp_pkg.sv =====
// shared types, constants and register codes for the packed genotype dot product core
package gdp_pkg;

	localparam int CODES_PER_BYTE = 4;
	localparam int CODE_W         = 2;
	localparam int COUNT_W        = 3;
	localparam int EPS_W          = 32;
	localparam int MEAN_W         = 17;
	localparam int SCALE_W        = 32;
	localparam int ACC_W          = 64;
	localparam int LANE_WP_W      = EPS_W + CODE_W;
	localparam int SUM_WP_W       = LANE_WP_W + $clog2(CODES_PER_BYTE);
	localparam int SUM_EPS_W      = EPS_W + $clog2(CODES_PER_BYTE);

	localparam logic [7:0] DOSAGE_MAP_RST = 8'd144;
	localparam logic [3:0] VALID_MAP_RST  = 4'd13;

	typedef enum logic [0:0] {
		REG_DOSAGE_MAP = 1'b0,
		REG_VALID_MAP  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FIN_IDLE,
		FIN_MUL,
		FIN_ACC,
		FIN_HOLD
	} fin_state_t;

	typedef struct packed {
		logic               vld;
		logic               last;
		logic [MEAN_W-1:0]  mean;
		logic [SCALE_W-1:0] scale;
	} gdp_tail_t;

	typedef struct packed {
		logic               go;
		logic [MEAN_W-1:0]  mean;
		logic [SCALE_W-1:0] scale;
		logic [ACC_W-1:0]   ws;
		logic [ACC_W-1:0]   ms;
	} gdp_fin_req_t;

endpackage

// ===== hw/rtl/packed_genotype_dot_product_core.sv =====
// top level: config registers, four genotype lanes, merge stage and final scaling
// a result passes the lane registers, merge registers, finish steps and output register
// throughput: one byte per cycle while no last byte is in flight
// a last byte holds off input until five 33x33 partial products on one multiplier are done
// and the output register is loaded, longer while it still holds an earlier result
// reset: asynchronous active low; clears sums, valids and maps (dosage 144, valid 13)
module packed_genotype_dot_product_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [0:0]                            cfg_idx,
	input  logic [7:0]                            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            geno_byte,
	input  logic signed [gdp_pkg::EPS_W-1:0]      eps_0,
	input  logic signed [gdp_pkg::EPS_W-1:0]      eps_1,
	input  logic signed [gdp_pkg::EPS_W-1:0]      eps_2,
	input  logic signed [gdp_pkg::EPS_W-1:0]      eps_3,
	input  logic [gdp_pkg::COUNT_W-1:0]           elem_count,
	input  logic                                  last_byte,
	input  logic [gdp_pkg::MEAN_W-1:0]            mean_value,
	input  logic [gdp_pkg::SCALE_W-1:0]           scale_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [63:0]                    dot_result,
	output logic                                  saturated
);

	logic [7:0]                            dosage_map_q;
	logic [3:0]                            valid_map_q;
	logic                                  in_xfer;
	logic                                  fin_busy;
	logic signed [gdp_pkg::EPS_W-1:0]      eps_arr  [gdp_pkg::CODES_PER_BYTE];
	logic signed [gdp_pkg::LANE_WP_W-1:0]  wprod_s1 [gdp_pkg::CODES_PER_BYTE];
	logic signed [gdp_pkg::EPS_W-1:0]      meps_s1  [gdp_pkg::CODES_PER_BYTE];
	gdp_pkg::gdp_tail_t                    tail_s1;
	gdp_pkg::gdp_tail_t                    tail_s2;
	gdp_pkg::gdp_fin_req_t                 req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dosage_map_q <= gdp_pkg::DOSAGE_MAP_RST;
			valid_map_q  <= gdp_pkg::VALID_MAP_RST;
		end else if (cfg_we) begin
			unique case (gdp_pkg::cfg_reg_t'(cfg_idx))
				gdp_pkg::REG_DOSAGE_MAP: dosage_map_q <= cfg_data;
				gdp_pkg::REG_VALID_MAP:  valid_map_q  <= cfg_data[3:0];
			endcase
		end
	end

	assign in_ready = !fin_busy
		&& !(tail_s1.vld && tail_s1.last)
		&& !(tail_s2.vld && tail_s2.last);
	assign in_xfer = in_valid && in_ready;

	assign eps_arr[0] = eps_0;
	assign eps_arr[1] = eps_1;
	assign eps_arr[2] = eps_2;
	assign eps_arr[3] = eps_3;

	for (genvar g = 0; g < gdp_pkg::CODES_PER_BYTE; g++) begin : g_lane
		gdp_lane #(
			.LANE_IDX(g)
		) u_lane (
			.clk        (clk),
			.en         (in_xfer),
			.code       (geno_byte[gdp_pkg::CODE_W*g +: gdp_pkg::CODE_W]),
			.eps        (eps_arr[g]),
			.count      (elem_count),
			.dosage_map (dosage_map_q),
			.valid_map  (valid_map_q),
			.wprod_s1   (wprod_s1[g]),
			.meps_s1    (meps_s1[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_s1 <= '0;
		end else begin
			tail_s1.vld <= in_xfer;
			if (in_xfer) begin
				tail_s1.last  <= last_byte;
				tail_s1.mean  <= mean_value;
				tail_s1.scale <= scale_value;
			end
		end
	end

	gdp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.tail_s1  (tail_s1),
		.wprod_s1 (wprod_s1),
		.meps_s1  (meps_s1),
		.tail_s2  (tail_s2),
		.req      (req)
	);

	gdp_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.busy       (fin_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.dot_result (dot_result),
		.saturated  (saturated)
	);

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && last_byte) |=> !in_ready)
		else $error("input open behind a last byte");

endmodule

// ===== hw/rtl/gdp_lane.sv =====
// one genotype lane: code decode, count gating and dosage times residual
module gdp_lane #(
	parameter int LANE_IDX = 0
) (
	input  logic                                       clk,
	input  logic                                       en,
	input  logic [gdp_pkg::CODE_W-1:0]                 code,
	input  logic signed [gdp_pkg::EPS_W-1:0]           eps,
	input  logic [gdp_pkg::COUNT_W-1:0]                count,
	input  logic [7:0]                                 dosage_map,
	input  logic [3:0]                                 valid_map,
	output logic signed [gdp_pkg::LANE_WP_W-1:0]       wprod_s1,
	output logic signed [gdp_pkg::EPS_W-1:0]           meps_s1
);

	logic                                  active;
	logic [gdp_pkg::CODE_W-1:0]            dosage;
	logic signed [gdp_pkg::LANE_WP_W-1:0]  eps_x;
	logic signed [gdp_pkg::LANE_WP_W-1:0]  prod;

	assign active = (count > gdp_pkg::COUNT_W'(LANE_IDX)) && valid_map[code];
	assign dosage = dosage_map[gdp_pkg::CODE_W*code +: gdp_pkg::CODE_W];
	assign eps_x  = {{gdp_pkg::CODE_W{eps[gdp_pkg::EPS_W-1]}}, eps};

	always_comb begin
		case (dosage)
			2'd0:    prod = '0;
			2'd1:    prod = eps_x;
			2'd2:    prod = eps_x <<< 1;
			default: prod = eps_x + (eps_x <<< 1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wprod_s1 <= active ? prod : '0;
			meps_s1  <= active ? eps : '0;
		end
	end

endmodule

// ===== hw/rtl/gdp_merge.sv =====
// lane merge stage and the two running sums
module gdp_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  gdp_pkg::gdp_tail_t                    tail_s1,
	input  logic signed [gdp_pkg::LANE_WP_W-1:0]  wprod_s1 [gdp_pkg::CODES_PER_BYTE],
	input  logic signed [gdp_pkg::EPS_W-1:0]      meps_s1 [gdp_pkg::CODES_PER_BYTE],
	output gdp_pkg::gdp_tail_t                    tail_s2,
	output gdp_pkg::gdp_fin_req_t                 req
);

	localparam int SW = gdp_pkg::SUM_WP_W;
	localparam int SM = gdp_pkg::SUM_EPS_W;
	localparam int AW = gdp_pkg::ACC_W;

	logic signed [SW-1:0] wsum;
	logic signed [SM-1:0] msum;
	logic signed [SW-1:0] wsum_s2;
	logic signed [SM-1:0] msum_s2;
	logic [AW-1:0]        weighted_q;
	logic [AW-1:0]        masked_q;
	logic [AW-1:0]        ws_next;
	logic [AW-1:0]        ms_next;

	always_comb begin
		wsum = '0;
		msum = '0;
		for (int i = 0; i < gdp_pkg::CODES_PER_BYTE; i++) begin
			wsum = wsum + SW'(wprod_s1[i]);
			msum = msum + SM'(meps_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_s2 <= '0;
		end else begin
			tail_s2 <= tail_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_s1.vld) begin
			wsum_s2 <= wsum;
			msum_s2 <= msum;
		end
	end

	assign ws_next = weighted_q + {{(AW-SW){wsum_s2[SW-1]}}, wsum_s2};
	assign ms_next = masked_q + {{(AW-SM){msum_s2[SM-1]}}, msum_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_q <= '0;
			masked_q   <= '0;
		end else if (tail_s2.vld) begin
			weighted_q <= tail_s2.last ? '0 : ws_next;
			masked_q   <= tail_s2.last ? '0 : ms_next;
		end
	end

	assign req.go    = tail_s2.vld && tail_s2.last;
	assign req.mean  = tail_s2.mean;
	assign req.scale = tail_s2.scale;
	assign req.ws    = ws_next;
	assign req.ms    = ms_next;

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |=> (weighted_q == '0 && masked_q == '0))
		else $error("sums not cleared after last byte");

endmodule

// ===== hw/rtl/gdp_finish.sv =====
// final scaling: shared multiplier over five partial products, rounding, saturation, output register
module gdp_finish (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gdp_pkg::gdp_fin_req_t         req,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [63:0]            dot_result,
	output logic                          saturated
);

	localparam logic [2:0] STEP_MS_LO = 3'd0;
	localparam logic [2:0] STEP_MS_HI = 3'd1;
	localparam logic [2:0] STEP_T_LO  = 3'd2;
	localparam logic [2:0] STEP_T_MID = 3'd3;
	localparam logic [2:0] STEP_T_HI  = 3'd4;

	gdp_pkg::fin_state_t state_q;
	gdp_pkg::fin_state_t state_d;

	logic [2:0]                    step_q;
	logic [gdp_pkg::ACC_W-1:0]     ms_q;
	logic [gdp_pkg::MEAN_W-1:0]    mean_q;
	logic [gdp_pkg::SCALE_W-1:0]   scale_q;
	logic [81:0]                   t_q;
	logic [113:0]                  p_q;
	logic signed [32:0]            mul_a;
	logic signed [32:0]            mul_b;
	logic signed [65:0]            prod_q;
	logic [113:0]                  prod_ext;
	logic [113:0]                  prod_sh;
	logic [81:0]                   q;
	logic                          fits;
	logic [63:0]                   res;
	logic                          load_out;
	logic                          out_valid_q;
	logic [63:0]                   dot_q;
	logic                          sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdp_pkg::FIN_IDLE;
			step_q  <= STEP_MS_LO;
		end else begin
			state_q <= state_d;
			if (state_q == gdp_pkg::FIN_IDLE) begin
				step_q <= STEP_MS_LO;
			end else if (state_q == gdp_pkg::FIN_ACC) begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			gdp_pkg::FIN_IDLE: begin
				if (req.go) state_d = gdp_pkg::FIN_MUL;
			end
			gdp_pkg::FIN_MUL: begin
				state_d = gdp_pkg::FIN_ACC;
			end
			gdp_pkg::FIN_ACC: begin
				state_d = (step_q == STEP_T_HI) ? gdp_pkg::FIN_HOLD : gdp_pkg::FIN_MUL;
			end
			gdp_pkg::FIN_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = gdp_pkg::FIN_IDLE;
				end
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			STEP_MS_LO: begin
				mul_a = {1'b0, ms_q[31:0]};
				mul_b = {16'd0, mean_q};
			end
			STEP_MS_HI: begin
				mul_a = {ms_q[63], ms_q[63:32]};
				mul_b = {16'd0, mean_q};
			end
			STEP_T_LO: begin
				mul_a = {1'b0, t_q[31:0]};
				mul_b = {1'b0, scale_q};
			end
			STEP_T_MID: begin
				mul_a = {1'b0, t_q[63:32]};
				mul_b = {1'b0, scale_q};
			end
			STEP_T_HI: begin
				mul_a = {{15{t_q[81]}}, t_q[81:64]};
				mul_b = {1'b0, scale_q};
			end
			default: ;
		endcase
	end

	assign prod_ext = {{48{prod_q[65]}}, prod_q};

	always_comb begin
		case (step_q) inside
			STEP_MS_HI, STEP_T_MID: prod_sh = prod_ext << 32;
			STEP_T_HI:              prod_sh = prod_ext << 64;
			default:                prod_sh = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == gdp_pkg::FIN_IDLE && req.go) begin
			ms_q    <= req.ms;
			mean_q  <= req.mean;
			scale_q <= req.scale;
			t_q     <= {{2{req.ws[63]}}, req.ws, 16'd0};
			p_q     <= {82'd0, 1'b1, 31'd0};
		end
		if (state_q == gdp_pkg::FIN_MUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == gdp_pkg::FIN_ACC) begin
			if (step_q == STEP_MS_LO || step_q == STEP_MS_HI) begin
				t_q <= t_q - prod_sh[81:0];
			end else begin
				p_q <= p_q + prod_sh;
			end
		end
	end

	assign q    = p_q[113:32];
	assign fits = (&q[81:63]) || !(|q[81:63]);
	assign res  = fits ? q[63:0] : (q[81] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			dot_q <= res;
			sat_q <= !fits;
		end
	end

	assign busy       = (state_q != gdp_pkg::FIN_IDLE);
	assign out_valid  = out_valid_q;
	assign dot_result = dot_q;
	assign saturated  = sat_q;

	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> state_q == gdp_pkg::FIN_IDLE)
		else $error("finish request while busy");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gdp_pkg::FIN_ACC |-> step_q <= STEP_T_HI)
		else $error("partial product step out of range");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid)
		else $error("loaded result not presented");

endmodule

// ===== tb/tb_packed_genotype_dot_product_core.sv =====
// self-checking testbench for the packed genotype dot product core
`timescale 1ns / 1ps

module tb_packed_genotype_dot_product_core;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_BYTES  = 150;
	localparam int PHASE_BYTES = 230;
	localparam logic signed [127:0] RES_HI = 128'sh7fff_ffff_ffff_ffff;
	localparam logic signed [127:0] RES_LO = -RES_HI - 128'sd1;
	localparam logic [31:0] EPS_MAX = 32'h7fff_ffff;
	localparam logic [31:0] EPS_MIN = 32'h8000_0000;

	typedef struct {
		logic [7:0]                     geno;
		logic [3:0][gdp_pkg::EPS_W-1:0] eps;
		logic [gdp_pkg::COUNT_W-1:0]    count;
		logic                           last;
		logic [gdp_pkg::MEAN_W-1:0]     mean;
		logic [gdp_pkg::SCALE_W-1:0]    scale;
	} geno_item_t;

	typedef struct {
		logic [63:0] dot;
		logic        sat;
	} dot_expect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	gdp_pkg::cfg_reg_t cfg_idx = gdp_pkg::REG_DOSAGE_MAP;
	logic [7:0] cfg_data = 8'd0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] geno_byte = 8'd0;
	logic signed [gdp_pkg::EPS_W-1:0] eps_0 = '0;
	logic signed [gdp_pkg::EPS_W-1:0] eps_1 = '0;
	logic signed [gdp_pkg::EPS_W-1:0] eps_2 = '0;
	logic signed [gdp_pkg::EPS_W-1:0] eps_3 = '0;
	logic [gdp_pkg::COUNT_W-1:0] elem_count = '0;
	logic last_byte = 1'b0;
	logic [gdp_pkg::MEAN_W-1:0] mean_value = '0;
	logic [gdp_pkg::SCALE_W-1:0] scale_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [63:0] dot_result;
	logic saturated;

	logic [7:0]  dosage_map = gdp_pkg::DOSAGE_MAP_RST;
	logic [3:0]  valid_map  = gdp_pkg::VALID_MAP_RST;
	logic [63:0] weighted_acc = '0;
	logic [63:0] masked_acc = '0;
	dot_expect_t expected_dots[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;

	packed_genotype_dot_product_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.geno_byte(geno_byte),
		.eps_0(eps_0),
		.eps_1(eps_1),
		.eps_2(eps_2),
		.eps_3(eps_3),
		.elem_count(elem_count),
		.last_byte(last_byte),
		.mean_value(mean_value),
		.scale_value(scale_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dot_result(dot_result),
		.saturated(saturated)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("packed_genotype_dot_product_core test failed");
			$finish;
		end
	end

	function automatic int pick_len();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// accumulate one byte and, on the last byte, score the marker
	function automatic void score_byte(input geno_item_t b);
		int n;
		logic [1:0] code;
		logic [1:0] dos;
		logic [63:0] e;
		logic signed [127:0] wsx;
		logic signed [127:0] msx;
		logic signed [127:0] diff;
		logic signed [127:0] prod;
		logic signed [127:0] q;
		dot_expect_t r;
		n = (b.count > gdp_pkg::CODES_PER_BYTE) ? gdp_pkg::CODES_PER_BYTE : int'(b.count);
		for (int k = 0; k < n; k++) begin
			code = b.geno[2*k +: 2];
			dos  = dosage_map[2*code +: 2];
			if (valid_map[code]) begin
				e = {{32{b.eps[k][31]}}, b.eps[k]};
				weighted_acc = weighted_acc + e * dos;
				masked_acc   = masked_acc + e;
			end
		end
		if (!b.last)
			return;
		wsx  = $signed(weighted_acc);
		msx  = $signed(masked_acc);
		diff = (wsx <<< 16) - msx * $signed({111'd0, b.mean});
		prod = diff * $signed({96'd0, b.scale}) + (128'sd1 <<< 31);
		q    = prod >>> 32;
		if (q > RES_HI) begin
			r.dot = 64'h7fff_ffff_ffff_ffff;
			r.sat = 1'b1;
		end else if (q < RES_LO) begin
			r.dot = 64'h8000_0000_0000_0000;
			r.sat = 1'b1;
		end else begin
			r.dot = q[63:0];
			r.sat = 1'b0;
		end
		expected_dots.push_back(r);
		weighted_acc = '0;
		masked_acc   = '0;
	endfunction

	function automatic geno_item_t make_byte(input logic [7:0] geno, input logic [31:0] e0,
			input logic [31:0] e1, input logic [31:0] e2, input logic [31:0] e3,
			input logic [2:0] count, input logic last, input logic [16:0] mean,
			input logic [31:0] scale);
		geno_item_t b;
		b.geno  = geno;
		b.eps   = {e3, e2, e1, e0};
		b.count = count;
		b.last  = last;
		b.mean  = mean;
		b.scale = scale;
		return b;
	endfunction

	function automatic geno_item_t random_byte(input logic last);
		geno_item_t b;
		b.geno = 8'($urandom_range(0, 255));
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 7))
				0: b.eps[k] = EPS_MAX;
				1: b.eps[k] = EPS_MIN;
				2: b.eps[k] = 32'($urandom_range(0, 262143)) - 32'd131072;
				3: b.eps[k] = '0;
				default: b.eps[k] = $urandom;
			endcase
		end
		if ($urandom_range(0, 9) == 0)
			b.count = 3'($urandom_range(0, 7));
		else if (last && $urandom_range(0, 2) == 0)
			b.count = 3'($urandom_range(1, 4));
		else
			b.count = 3'd4;
		b.last = last;
		case ($urandom_range(0, 5))
			0: b.mean = '0;
			1: b.mean = 17'h1ffff;
			default: b.mean = 17'($urandom_range(0, 131071));
		endcase
		case ($urandom_range(0, 6))
			0: b.scale = '0;
			1: b.scale = 32'hffff_ffff;
			2: b.scale = 32'h0001_0000;
			default: b.scale = $urandom;
		endcase
		return b;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (mismatch_count <= 20)
			$display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $time);
	endtask

	always @(posedge clk) begin : check_results
		dot_expect_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_dots.size() == 0) begin
				report_mismatch("unexpected result transfer", dot_result, '0);
			end else begin
				want = expected_dots.pop_front();
				if (dot_result !== want.dot)
					report_mismatch("dot_result", dot_result, want.dot);
				if (saturated !== want.sat)
					report_mismatch("saturated", 64'(saturated), 64'(want.sat));
			end
		end
	end

	always @(posedge clk) begin : drive_out_ready
		int stall_left;
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (stalls_on && $urandom_range(0, 5) == 0)
				stall_left = pick_len();
		end
	end

	task automatic send_byte(input geno_item_t b);
		int gap;
		in_valid    <= 1'b1;
		geno_byte   <= b.geno;
		eps_0       <= b.eps[0];
		eps_1       <= b.eps[1];
		eps_2       <= b.eps[2];
		eps_3       <= b.eps[3];
		elem_count  <= b.count;
		last_byte   <= b.last;
		mean_value  <= b.mean;
		scale_value <= b.scale;
		do @(posedge clk); while (!in_ready);
		score_byte(b);
		gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_results(input int settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_dots.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_maps(input logic [7:0] dosage, input logic [7:0] valid);
		wait_results(16);
		cfg_we   <= 1'b1;
		cfg_idx  <= gdp_pkg::REG_DOSAGE_MAP;
		cfg_data <= dosage;
		@(posedge clk);
		cfg_idx  <= gdp_pkg::REG_VALID_MAP;
		cfg_data <= valid;
		@(posedge clk);
		cfg_we <= 1'b0;
		dosage_map = dosage;
		valid_map  = valid[3:0];
	endtask

	// reset maps: extremes, partial and oversized counts, ties in rounding
	task automatic test_default_maps();
		send_byte(make_byte(8'he4, EPS_MAX, EPS_MIN, EPS_MAX, EPS_MIN, 3'd4, 1'b1, 17'd0,
			32'h0001_0000));
		send_byte(make_byte(8'h00, '0, '0, '0, '0, 3'd0, 1'b1, 17'h1ffff, 32'hffff_ffff));
		send_byte(make_byte(8'hff, EPS_MAX, EPS_MAX, EPS_MAX, EPS_MAX, 3'd5, 1'b0, 17'h1ffff,
			32'hffff_ffff));
		send_byte(make_byte(8'haa, EPS_MIN, EPS_MIN, EPS_MIN, EPS_MIN, 3'd6, 1'b0, 17'd0, '0));
		send_byte(make_byte(8'h55, 32'h1234_5678, 32'hedcb_a988, EPS_MAX, 32'h1, 3'd7, 1'b1,
			17'h1ffff, 32'hffff_ffff));
		send_byte(make_byte(8'h1b, 32'h0001_0000, 32'hffff_0000, 32'h0002_8000, EPS_MAX, 3'd1,
			1'b0, 17'h1ffff, 32'hffff_ffff));
		send_byte(make_byte(8'he4, 32'h0003_0000, 32'hfff0_0000, 32'h0000_8000, EPS_MIN, 3'd2,
			1'b0, 17'd0, '0));
		send_byte(make_byte(8'hc6, EPS_MAX, 32'h0000_0001, 32'hffff_ffff, EPS_MIN, 3'd3, 1'b1,
			17'h10000, 32'h0002_0000));
		send_byte(make_byte(8'h03, 32'h1, '0, '0, '0, 3'd1, 1'b1, 17'd0, 32'h0000_4000));
		send_byte(make_byte(8'h03, 32'hffff_ffff, '0, '0, '0, 3'd1, 1'b1, 17'd0, 32'h0000_4000));
		send_byte(make_byte(8'hff, EPS_MAX, EPS_MAX, EPS_MAX, EPS_MAX, 3'd4, 1'b1, 17'h1ffff,
			'0));
		send_byte(make_byte(8'hff, 32'h0002_0000, '0, '0, '0, 3'd1, 1'b1, 17'h1ffff,
			32'hffff_ffff));
	endtask

	task automatic test_map_extremes();
		logic [15:0] map_sets[5];
		map_sets = '{16'h00_00, 16'hff_0f, 16'he4_0f, 16'h1b_f5, 16'h90_0d};
		foreach (map_sets[s]) begin
			set_maps(map_sets[s][15:8], map_sets[s][7:0]);
			send_byte(random_byte(1'b0));
			send_byte(random_byte(1'b1));
		end
	endtask

	// long vectors build large sums of both signs
	task automatic test_long_vectors();
		geno_item_t b;
		set_maps(8'hff, 8'h0f);
		gaps_on = 1'b0;
		for (int sgn = 0; sgn < 2; sgn++) begin
			for (int i = 0; i < LONG_BYTES; i++) begin
				b = random_byte(i == LONG_BYTES - 1);
				for (int k = 0; k < 4; k++)
					b.eps[k] = sgn ? (EPS_MIN | $urandom_range(0, 255))
						: (32'h7fff_0000 | $urandom_range(0, 65535));
				b.count = 3'd4;
				b.mean  = '0;
				b.scale = 32'hffff_ffff;
				send_byte(b);
			end
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_pause_for_results();
		int len;
		set_maps(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		for (int v = 0; v < 6; v++) begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send_byte(random_byte(i == len - 1));
			wait_results(0);
		end
	endtask

	task automatic test_random_phases();
		logic [15:0] map_sets[5];
		int sent;
		int len;
		int pick;
		map_sets = '{16'h90_0d, 16'he4_0f, 16'hff_0f, 16'h00_0f, 16'h1b_0e};
		for (int p = 0; p < 5; p++) begin
			if (p >= 3)
				set_maps(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			else
				set_maps(map_sets[p][15:8], map_sets[p][7:0]);
			gaps_on   = (p != 1 && p != 4);
			stalls_on = (p != 2 && p != 4);
			sent = 0;
			while (sent < PHASE_BYTES) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					len = $urandom_range(1, 4);
				else if (pick < 9)
					len = $urandom_range(5, 12);
				else
					len = $urandom_range(13, 40);
				for (int i = 0; i < len; i++)
					send_byte(random_byte(i == len - 1));
				sent += len;
				if ($urandom_range(0, 19) == 0)
					wait_results(0);
			end
		end
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_maps();
		test_map_extremes();
		test_long_vectors();
		test_pause_for_results();
		test_random_phases();
		wait_results(30);
		if (mismatch_count == 0 && expected_dots.size() == 0)
			$display("packed_genotype_dot_product_core test passed");
		else
			$display("packed_genotype_dot_product_core test failed");
		$finish;
	end

endmodule
